[design/dday_pkg.sv]
// Package for the date day-difference unit: widths, constants, the controller
// state type, the command struct, and the month offset table.
// Depends on nothing; every other file of the block refers to it by scope.
package dday_pkg;

	// Field and internal widths.
	localparam int DATE_W  = 27;  // binary value of the decimal YYYYMMDD
	localparam int YEAR_W  = 14;  // quotient of a date by 10000
	localparam int REM_W   = 14;  // remainder below 10000 (MMDD)
	localparam int MONTH_W = 7;   // month field, 0 to 99
	localparam int DAY_W   = 7;   // day field, 0 to 99
	localparam int QTR_W   = 13;  // leap days before a year
	localparam int MOFF_W  = 9;   // days before a month, up to 335
	localparam int ORD_W   = 23;  // day ordinal of a date
	localparam int DIFF_W  = 23;  // signed result
	localparam int RECIP_W = 13;  // width of the reciprocal of 100

	// Arithmetic constants.
	localparam int YEAR_DIV        = 10000;
	localparam int YEAR_PRE_SHIFT  = 4;         // 10000 = 16 * 625
	localparam int RECIP_625       = 13743896;  // ceil(2^33 / 625), exact for 23-bit values
	localparam int RECIP_625_SHIFT = 33;
	localparam int RECIP_625_W     = 24;
	localparam int MONTH_SCALE     = 100;
	localparam int RECIP_100       = 5243;  // ceil(2^19 / 100), exact below 43699
	localparam int RECIP_SHIFT     = 19;
	localparam int DAYS_PER_YEAR   = 365;
	localparam int DIFF_LIMIT      = 3660000;
	localparam int MONTH_JAN       = 1;
	localparam int MONTH_FEB       = 2;
	localparam int MONTH_DEC       = 12;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DIV,
		ST_REM,
		ST_SPLIT,
		ST_ORD1,
		ST_ORD2,
		ST_DIFF
	} state_t;

	typedef struct packed {
		logic load;
		logic quot;
		logic rem;
		logic split;
		logic ord1;
		logic ord2;
		logic finish;
	} dp_cmd_t;

	// Days in the whole months before a month, from the month lengths
	// 31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31 of a common year.
	function automatic logic [MOFF_W-1:0] days_before_month(input logic [MONTH_W-1:0] month);
		logic [MOFF_W-1:0] days;
		case (month)
			7'd1:    days = 9'd0;
			7'd2:    days = 9'd31;
			7'd3:    days = 9'd59;
			7'd4:    days = 9'd90;
			7'd5:    days = 9'd120;
			7'd6:    days = 9'd151;
			7'd7:    days = 9'd181;
			7'd8:    days = 9'd212;
			7'd9:    days = 9'd243;
			7'd10:   days = 9'd273;
			7'd11:   days = 9'd304;
			7'd12:   days = 9'd334;
			default: days = 9'd0;
		endcase
		return days;
	endfunction

endpackage

[design/dday_req_if.sv]
// Request channel of the date day-difference unit: valid, ready and two dates.
// Depends on dday_pkg for the date width.
interface dday_req_if;
	logic                         valid;
	logic                         ready;
	logic [dday_pkg::DATE_W-1:0]  first_date;
	logic [dday_pkg::DATE_W-1:0]  second_date;

	modport source(output valid, output first_date, output second_date, input ready);
	modport sink(input valid, input first_date, input second_date, output ready);
endinterface

[design/dday_rsp_if.sv]
// Result channel of the date day-difference unit: valid, ready, day count, flag.
// Depends on dday_pkg for the result width.
interface dday_rsp_if;
	logic                                valid;
	logic                                ready;
	logic signed [dday_pkg::DIFF_W-1:0]  day_difference;
	logic                                bad_month;

	modport source(output valid, output day_difference, output bad_month, input ready);
	modport sink(input valid, input day_difference, input bad_month, output ready);
endinterface

[design/date_day_difference_unit.sv]
// Top level of the date day-difference unit: controller plus datapath.
// Depends on dday_pkg, dday_req_if, dday_rsp_if, dday_ctrl and dday_datapath.
//
// Channel   Dir  Payload                              Word accepted when
// request   in   first_date[26:0], second_date[26:0]  request.valid && request.ready
// result    out  day_difference[22:0] s, bad_month    result.valid && result.ready
//
// Each word passes through the accept, one reciprocal multiply that yields the
// years, the remainder below 10000, the month split, two ordinal steps and
// the difference. The result becomes valid as the difference step ends, when
// the controller returns to idle and can take the next request word.
// The result sits in an output register; a new request word is taken while it
// waits, and only the difference cycle stalls until that register is free.
// Reset is asynchronous and active low; it clears the controller, the valid
// flag and the output register, and the unit then accepts a word as soon as
// reset is released.
module date_day_difference_unit (
	input  logic        clk,
	input  logic        arst_n,
	dday_req_if.sink    request,
	dday_rsp_if.source  result
);

	dday_pkg::dp_cmd_t    cmd;

	// The controller owns the handshakes and walks the datapath through the
	// divide, remainder, split, ordinal and difference steps.
	dday_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (request.valid),
		.req_ready (request.ready),
		.rsp_valid (result.valid),
		.rsp_ready (result.ready),
		.cmd       (cmd)
	);

	// Both dates run in parallel lanes of the datapath; the day ordinals are
	// subtracted, saturated, and forced to zero when a month is out of range.
	dday_datapath u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.first_date     (request.first_date),
		.second_date    (request.second_date),
		.day_difference (result.day_difference),
		.bad_month      (result.bad_month)
	);

endmodule

[design/dday_datapath.sv]
// Datapath of the date day-difference unit: two date lanes with a reciprocal
// multiplier for the division by 10000, month and day split, ordinal sum and
// saturated difference. Depends on dday_pkg; driven by dday_ctrl through dp_cmd_t.
module dday_datapath (
	input  logic                                clk,
	input  logic                                arst_n,
	input  dday_pkg::dp_cmd_t                   cmd,
	input  logic [dday_pkg::DATE_W-1:0]         first_date,
	input  logic [dday_pkg::DATE_W-1:0]         second_date,
	output logic signed [dday_pkg::DIFF_W-1:0]  day_difference,
	output logic                                bad_month
);

	localparam int DATE_W  = dday_pkg::DATE_W;
	localparam int YEAR_W  = dday_pkg::YEAR_W;
	localparam int REM_W   = dday_pkg::REM_W;
	localparam int MONTH_W = dday_pkg::MONTH_W;
	localparam int DAY_W   = dday_pkg::DAY_W;
	localparam int QTR_W   = dday_pkg::QTR_W;
	localparam int MOFF_W  = dday_pkg::MOFF_W;
	localparam int ORD_W   = dday_pkg::ORD_W;
	localparam int DIFF_W  = dday_pkg::DIFF_W;
	localparam int PROD_W  = REM_W + dday_pkg::RECIP_W;
	localparam int PRE_SH  = dday_pkg::YEAR_PRE_SHIFT;
	localparam int QPROD_W = (DATE_W - PRE_SH) + dday_pkg::RECIP_625_W;

	localparam logic signed [ORD_W:0] LIM_POS = (ORD_W+1)'(dday_pkg::DIFF_LIMIT);
	localparam logic signed [ORD_W:0] LIM_NEG = -LIM_POS;

	logic [DATE_W-1:0]  date_in   [2];
	logic [DATE_W-1:0]  dvd_q     [2];   // the date as loaded
	logic [YEAR_W-1:0]  year_q    [2];
	logic [REM_W-1:0]   rem_q     [2];
	logic [MONTH_W-1:0] month_q   [2];
	logic [DAY_W-1:0]   day_q     [2];
	logic [ORD_W-1:0]   yr365_q   [2];
	logic [QTR_W-1:0]   quarter_q [2];
	logic [MOFF_W-1:0]  moff_q    [2];
	logic [ORD_W-1:0]   ord_q     [2];
	logic               bad_q;
	logic               bad_out_q;
	logic [DIFF_W-1:0]  diff_out_q;

	logic [QPROD_W-1:0] qprod     [2];
	logic [REM_W-1:0]   rem_nx    [2];
	logic [PROD_W-1:0]  prod      [2];
	logic [YEAR_W:0]    year_p3   [2];
	logic               month_ok  [2];
	logic [REM_W-1:0]   day_full  [2];
	logic [MOFF_W-1:0]  moff_nx   [2];
	logic signed [ORD_W:0] diff_w;
	logic signed [ORD_W:0] diff_sat;

	assign date_in[0] = first_date;
	assign date_in[1] = second_date;

	always_comb begin
		for (int i = 0; i < 2; i++) begin
			// The date over 16, times the reciprocal of 625, gives the year.
			qprod[i]  = QPROD_W'(dvd_q[i][DATE_W-1:PRE_SH])
			          * QPROD_W'(dday_pkg::RECIP_625);
			// The remainder is below 10000, so 14-bit wrapping arithmetic is exact.
			rem_nx[i] = dvd_q[i][REM_W-1:0]
			          - REM_W'(year_q[i]) * REM_W'(dday_pkg::YEAR_DIV);
			prod[i]   = PROD_W'(rem_q[i]) * PROD_W'(dday_pkg::RECIP_100);
			year_p3[i] = (YEAR_W+1)'(year_q[i]) + (YEAR_W+1)'(3);
			month_ok[i] = month_q[i] inside {[dday_pkg::MONTH_JAN : dday_pkg::MONTH_DEC]};
			day_full[i] = rem_q[i] - REM_W'(month_q[i]) * REM_W'(dday_pkg::MONTH_SCALE);
			// A year divisible by four adds its leap day after February.
			moff_nx[i] = dday_pkg::days_before_month(month_q[i])
			           + MOFF_W'((year_q[i][1:0] == 2'b00)
			                     && (month_q[i] > MONTH_W'(dday_pkg::MONTH_FEB)));
		end
		diff_w = $signed({1'b0, ord_q[0]}) - $signed({1'b0, ord_q[1]});
		if (diff_w > LIM_POS) begin
			diff_sat = LIM_POS;
		end else if (diff_w < LIM_NEG) begin
			diff_sat = LIM_NEG;
		end else begin
			diff_sat = diff_w;
		end
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < 2; i++) begin
			if (cmd.load) begin
				dvd_q[i] <= date_in[i];
			end
			if (cmd.quot) begin
				year_q[i] <= qprod[i][dday_pkg::RECIP_625_SHIFT +: YEAR_W];
			end
			if (cmd.rem) begin
				rem_q[i] <= rem_nx[i];
			end
			if (cmd.split) begin
				month_q[i] <= prod[i][dday_pkg::RECIP_SHIFT +: MONTH_W];
			end
			if (cmd.ord1) begin
				yr365_q[i]   <= ORD_W'(year_q[i]) * ORD_W'(dday_pkg::DAYS_PER_YEAR);
				quarter_q[i] <= year_p3[i][YEAR_W:2];
				moff_q[i]    <= moff_nx[i];
				day_q[i]     <= day_full[i][DAY_W-1:0];
			end
			if (cmd.ord2) begin
				ord_q[i] <= yr365_q[i] + ORD_W'(quarter_q[i]) + ORD_W'(moff_q[i])
				          + ORD_W'(day_q[i]);
			end
		end
		if (cmd.ord1) begin
			bad_q <= !month_ok[0] || !month_ok[1];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bad_out_q  <= 1'b0;
			diff_out_q <= '0;
		end else if (cmd.finish) begin
			bad_out_q  <= bad_q;
			diff_out_q <= bad_q ? '0 : diff_sat[DIFF_W-1:0];
		end
	end

	assign day_difference  = $signed(diff_out_q);
	assign bad_month       = bad_out_q;

endmodule

[design/dday_ctrl.sv]
// Controller of the date day-difference unit: sequencing state machine and the
// result valid flag. Depends on dday_pkg; commands dday_datapath.
module dday_ctrl (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  req_valid,
	output logic                  req_ready,
	output logic                  rsp_valid,
	input  logic                  rsp_ready,
	output dday_pkg::dp_cmd_t     cmd
);

	dday_pkg::state_t state_q;
	dday_pkg::state_t state_nx;
	logic             rsp_valid_q;
	logic             out_free;

	// The output register may be reloaded when empty or emptied this cycle.
	assign out_free = !rsp_valid_q || rsp_ready;

	always_comb begin
		state_nx = state_q;
		case (state_q)
			dday_pkg::ST_IDLE:  if (req_valid) state_nx = dday_pkg::ST_DIV;
			dday_pkg::ST_DIV:   state_nx = dday_pkg::ST_REM;
			dday_pkg::ST_REM:   state_nx = dday_pkg::ST_SPLIT;
			dday_pkg::ST_SPLIT: state_nx = dday_pkg::ST_ORD1;
			dday_pkg::ST_ORD1:  state_nx = dday_pkg::ST_ORD2;
			dday_pkg::ST_ORD2:  state_nx = dday_pkg::ST_DIFF;
			dday_pkg::ST_DIFF:  if (out_free) state_nx = dday_pkg::ST_IDLE;
			default:            state_nx = dday_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		cmd       = '0;
		req_ready = 1'b0;
		case (state_q)
			dday_pkg::ST_IDLE: begin
				req_ready = 1'b1;
				cmd.load  = req_valid;
			end
			dday_pkg::ST_DIV:   cmd.quot   = 1'b1;
			dday_pkg::ST_REM:   cmd.rem    = 1'b1;
			dday_pkg::ST_SPLIT: cmd.split  = 1'b1;
			dday_pkg::ST_ORD1:  cmd.ord1   = 1'b1;
			dday_pkg::ST_ORD2:  cmd.ord2   = 1'b1;
			dday_pkg::ST_DIFF:  cmd.finish = out_free;
			default:            cmd        = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= dday_pkg::ST_IDLE;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_nx;
			if (cmd.finish) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	assign rsp_valid = rsp_valid_q;

endmodule

[design/dday_checker.sv]
// Port-level checker for the date day-difference unit and its bind statement.
// Depends on dday_pkg; attaches to date_day_difference_unit.
module dday_checker (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                req_valid,
	input  logic                                req_ready,
	input  logic                                rsp_valid,
	input  logic                                rsp_ready,
	input  logic signed [dday_pkg::DIFF_W-1:0]  day_difference,
	input  logic                                bad_month
);

	localparam logic signed [dday_pkg::DIFF_W-1:0] LIM =
		dday_pkg::DIFF_W'(dday_pkg::DIFF_LIMIT);

	// A stalled result word holds its value.
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(day_difference)
		&& $stable(bad_month))
		else $error("result word changed while stalled");

	// After a request word is taken the unit is busy.
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready |=> !req_ready)
		else $error("request accepted back to back");

	// A new result only appears out of a busy cycle.
	a_result_from_busy: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rsp_valid) |-> !$past(req_ready))
		else $error("result appeared without work in flight");

	// A bad month yields a zero day count.
	a_bad_month_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && bad_month |-> day_difference == '0)
		else $error("nonzero day count with a bad month");

	// The day count stays within its saturation limits.
	a_diff_range: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> (day_difference <= LIM) && (day_difference >= -LIM))
		else $error("day count outside its limits");

endmodule

bind date_day_difference_unit dday_checker u_dday_checker (
	.clk            (clk),
	.arst_n         (arst_n),
	.req_valid      (request.valid),
	.req_ready      (request.ready),
	.rsp_valid      (result.valid),
	.rsp_ready      (result.ready),
	.day_difference (result.day_difference),
	.bad_month      (result.bad_month)
);

[tb/sv/date_diff_monitor.sv]
`timescale 1ns / 100ps
// Result monitor for the date day-difference unit: predicts each day count
// from the accepted request words and compares it with the result words.
// Depends on dday_pkg and the dday_req_if / dday_rsp_if channel interfaces.
module date_diff_monitor (
	input  logic  clk,
	input  logic  arst_n,
	dday_req_if   request,
	dday_rsp_if   result,
	output int    mismatches,
	output int    outstanding
);

	typedef struct packed {
		logic signed [dday_pkg::DIFF_W-1:0] diff;
		logic                               bad;
	} diff_word_t;

	diff_word_t expected_diffs[$];
	diff_word_t want;

	// Days from year 0 up to the given date; year 0 and every year divisible
	// by four carry a February 29.
	function automatic int unsigned date_ordinal(int unsigned y, int unsigned m,
	                                             int unsigned d);
		int unsigned total;
		total = y * dday_pkg::DAYS_PER_YEAR + (y + 3) / 4;
		for (int unsigned k = 1; k < m && k <= dday_pkg::MONTH_DEC; k++) begin
			if (k == dday_pkg::MONTH_FEB)
				total += (y % 4 == 0) ? 29 : 28;
			else if (k == 4 || k == 6 || k == 9 || k == 11)
				total += 30;
			else
				total += 31;
		end
		return total + d;
	endfunction

	function automatic diff_word_t predict_difference(logic [dday_pkg::DATE_W-1:0] a,
	                                                  logic [dday_pkg::DATE_W-1:0] b);
		int unsigned ya, ma, da, yb, mb, db;
		longint      span;
		diff_word_t  w;
		ya = a / dday_pkg::YEAR_DIV;
		ma = (a / dday_pkg::MONTH_SCALE) % dday_pkg::MONTH_SCALE;
		da = a % dday_pkg::MONTH_SCALE;
		yb = b / dday_pkg::YEAR_DIV;
		mb = (b / dday_pkg::MONTH_SCALE) % dday_pkg::MONTH_SCALE;
		db = b % dday_pkg::MONTH_SCALE;
		w.bad = ma < dday_pkg::MONTH_JAN || ma > dday_pkg::MONTH_DEC
		     || mb < dday_pkg::MONTH_JAN || mb > dday_pkg::MONTH_DEC;
		span  = 0;
		if (!w.bad) begin
			span = longint'(date_ordinal(ya, ma, da))
			     - longint'(date_ordinal(yb, mb, db));
			if (span > dday_pkg::DIFF_LIMIT)
				span = dday_pkg::DIFF_LIMIT;
			if (span < -dday_pkg::DIFF_LIMIT)
				span = -dday_pkg::DIFF_LIMIT;
		end
		w.diff = span[dday_pkg::DIFF_W-1:0];
		return w;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			expected_diffs.delete();
			mismatches  <= 0;
			outstanding <= 0;
		end else begin
			if (result.valid && result.ready) begin
				if (expected_diffs.size() == 0) begin
					if (mismatches < 10)
						$display("%0t: unexpected result word diff=%0d bad=%0b", $time,
						         result.day_difference, result.bad_month);
					mismatches <= mismatches + 1;
				end else begin
					want = expected_diffs.pop_front();
					if (result.day_difference !== want.diff
					    || result.bad_month !== want.bad) begin
						if (mismatches < 10)
							$display({"%0t: result mismatch: expected diff=%0d bad=%0b,",
							          " got diff=%0d bad=%0b"},
							         $time, want.diff, want.bad, result.day_difference,
							         result.bad_month);
						mismatches <= mismatches + 1;
					end
				end
			end
			if (request.valid && request.ready)
				expected_diffs.push_back(predict_difference(request.first_date,
				                                            request.second_date));
			outstanding <= expected_diffs.size();
		end
	end

endmodule

[tb/sv/tb.sv]
`timescale 1ns / 100ps
// Top of the date day-difference testbench: clock, reset, request stimulus,
// result back-pressure and the verdict. Depends on dday_pkg, the channel
// interfaces, date_day_difference_unit and date_diff_monitor.
module tb;

	// Kinds of date that the random part draws from.
	typedef enum int {
		DATE_PLAIN,
		DATE_ODD_DAY,
		DATE_BAD_MONTH,
		DATE_HUGE_YEAR,
		DATE_RAW
	} date_kind_t;

	localparam int CYCLE_LIMIT   = 600000;
	localparam int PHASE_WORDS   = 188;
	localparam int SETTLE_CYCLES = 40;

	logic clk;
	logic arst_n;
	int   mismatches;
	int   outstanding;
	int   cycle_count;
	int   gap_pct;
	int   stall_pct;

	dday_req_if request();
	dday_rsp_if result();

	date_day_difference_unit dut (
		.clk    (clk),
		.arst_n (arst_n),
		.request(request),
		.result (result)
	);

	date_diff_monitor u_diff_check (
		.clk        (clk),
		.arst_n     (arst_n),
		.request    (request),
		.result     (result),
		.mismatches (mismatches),
		.outstanding(outstanding)
	);

	initial clk = 1'b0;
	always #4 clk = ~clk;

	// The run is cut short if it hangs; the limit is far above the slowest
	// legal run, which is bounded by the controller steps of each word plus
	// sender gaps and receiver stalls.
	initial cycle_count = 0;
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("tb NOT OK");
			$finish;
		end
	end

	// The receiver stalls at random, with the stall share set per phase.
	// Ready changes only on the falling edge, one assignment per edge.
	always @(negedge clk)
		result.ready <= arst_n && ($urandom_range(99) >= stall_pct);

	// Builds one packed YYYYMMDD value of the requested kind.
	function automatic logic [dday_pkg::DATE_W-1:0] make_date(date_kind_t kind);
		int unsigned y, m, d, len;
		y = $urandom_range(9999);
		m = $urandom_range(dday_pkg::MONTH_DEC, dday_pkg::MONTH_JAN);
		d = $urandom_range(99);
		case (kind)
			DATE_PLAIN: begin
				if (m == dday_pkg::MONTH_FEB)
					len = (y % 4 == 0) ? 29 : 28;
				else if (m == 4 || m == 6 || m == 9 || m == 11)
					len = 30;
				else
					len = 31;
				d = $urandom_range(len, 1);
			end
			DATE_ODD_DAY: ;
			DATE_BAD_MONTH: begin
				m = $urandom_range(1) ? 0 : $urandom_range(99, 13);
			end
			DATE_HUGE_YEAR: begin
				y = $urandom_range(13421, 10000);
			end
			default: begin
				return dday_pkg::DATE_W'($urandom);
			end
		endcase
		return dday_pkg::DATE_W'(y * dday_pkg::YEAR_DIV + m * dday_pkg::MONTH_SCALE + d);
	endfunction

	// Offers one request word once the sender stops idling, deciding each cycle
	// with the set idle share, and returns once the unit has taken it. Valid is
	// only ever raised on a falling edge that did not also lower it, so each
	// step sees at most one assignment.
	task automatic send_word(input logic [dday_pkg::DATE_W-1:0] a,
	                         input logic [dday_pkg::DATE_W-1:0] b);
		@(negedge clk);
		while ($urandom_range(99) < gap_pct) begin
			request.valid <= 1'b0;
			@(negedge clk);
		end
		request.valid       <= 1'b1;
		request.first_date  <= a;
		request.second_date <= b;
		do
			@(posedge clk);
		while (!request.ready);
	endtask

	// Pauses the sender until every expected result word has come back.
	task automatic drain;
		@(negedge clk);
		request.valid <= 1'b0;
		while (outstanding != 0)
			@(posedge clk);
	endtask

	logic [dday_pkg::DATE_W-1:0] fd, sd;
	int                          pick;

	initial begin
		request.valid       = 1'b0;
		request.first_date  = '0;
		request.second_date = '0;
		result.ready        = 1'b0;
		gap_pct             = 0;
		stall_pct           = 0;
		arst_n              = 1'b0;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed words, sent with no idling on either side. They cover equal
		// dates, the widest legal span both ways, the leap day of year 0 and of
		// a century year, February of a common year, zero and oversized days,
		// bad months in each field, the all-ones input and saturation.
		send_word(27'd20240315, 27'd20240315);
		send_word(27'd99991231, 27'd00000101);
		send_word(27'd00000101, 27'd99991231);
		send_word(27'd00000301, 27'd00000101);
		send_word(27'd20240301, 27'd20240228);
		send_word(27'd20240301, 27'd20240201);
		send_word(27'd20230301, 27'd20230201);
		send_word(27'd19000301, 27'd19000201);
		send_word(27'd20240100, 27'd20231231);
		send_word(27'd20240299, 27'd20240301);
		send_word(27'd20241301, 27'd20240101);
		send_word(27'd20240101, 27'd20240001);
		send_word(27'd20249901, 27'd20240101);
		send_word(27'd00000000, 27'd00000000);
		send_word(27'h7FFFFFF, 27'd20240101);
		send_word(27'd134211231, 27'd00000101);
		send_word(27'd00000101, 27'd134211231);
		send_word(27'd134211299, 27'd100000101);
		send_word(27'd00001231, 27'd00000101);
		send_word(27'd19991231, 27'd20000101);
		send_word(27'd99990229, 27'd99990301);
		drain();

		// Random phases: no idling, sender gaps, receiver stalls, then both.
		// Each phase ends with the sender held until all results are back.
		for (int phase = 0; phase < 4; phase++) begin
			case (phase)
				0: begin gap_pct = 0;  stall_pct = 0;  end
				1: begin gap_pct = 63; stall_pct = 0;  end
				2: begin gap_pct = 0;  stall_pct = 63; end
				default: begin gap_pct = 23; stall_pct = 23; end
			endcase
			for (int n = 0; n < PHASE_WORDS; n++) begin
				pick = $urandom_range(99);
				if (pick < 70) begin
					fd = make_date(DATE_PLAIN);
					sd = make_date(DATE_PLAIN);
				end else if (pick < 80) begin
					// Same year on both sides, so only months and days differ.
					fd = make_date(DATE_PLAIN);
					sd = dday_pkg::DATE_W'((fd / dday_pkg::YEAR_DIV) * dday_pkg::YEAR_DIV
					     + make_date(DATE_PLAIN) % dday_pkg::YEAR_DIV);
				end else if (pick < 88) begin
					fd = make_date(DATE_ODD_DAY);
					sd = make_date(DATE_ODD_DAY);
				end else if (pick < 93) begin
					fd = make_date($urandom_range(1) ? DATE_BAD_MONTH : DATE_PLAIN);
					sd = make_date($urandom_range(1) ? DATE_BAD_MONTH : DATE_PLAIN);
				end else if (pick < 97) begin
					fd = make_date($urandom_range(1) ? DATE_HUGE_YEAR : DATE_PLAIN);
					sd = make_date($urandom_range(1) ? DATE_HUGE_YEAR : DATE_PLAIN);
				end else begin
					fd = make_date(DATE_RAW);
					sd = make_date(DATE_RAW);
				end
				send_word(fd, sd);
			end
			drain();
		end

		// A short settle lets any stray result word show up before the verdict.
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (mismatches == 0 && outstanding == 0)
			$display("tb OK");
		else
			$display("tb NOT OK");
		$finish;
	end

endmodule
